// ===== hdl/mctg_pkg.sv =====
// shared types, constants and widths for the midi clock transport generator
// no dependencies
package mctg_pkg;

    localparam int MAX_BLOCK = 4096;
    localparam int MAX_MSG   = 32;
    localparam int BLK_W     = 13;
    localparam int OFS_W     = 12;
    localparam int CNT_W     = 6;
    localparam int DIST_W    = 33;
    localparam int MUL_W     = 21;
    localparam int NUM_W     = 54;
    localparam int DIV_W     = 27;
    localparam int KK_W      = 17;

    localparam logic [7:0] ST_POS   = 8'hF2;
    localparam logic [7:0] ST_START = 8'hFA;
    localparam logic [7:0] ST_CONT  = 8'hFB;
    localparam logic [7:0] ST_CLOCK = 8'hF8;
    localparam logic [7:0] ST_STOP  = 8'hFC;

    localparam logic [1:0]  CFG_ENABLE = 2'd0;
    localparam logic [1:0]  CFG_RATE   = 2'd1;
    localparam logic [25:0] TEMPO_RST  = 26'd7864320;
    localparam logic [17:0] RATE_RST   = 18'd44100;

    typedef struct packed {
        logic [7:0]       status;
        logic [6:0]       dlo;
        logic [6:0]       dhi;
        logic [OFS_W-1:0] offset;
    } t_msg;

    typedef enum logic [3:0] {
        S_IDLE, S_EVAL, S_POS_F2, S_START_GO, S_START_WAIT, S_START_FA, S_START_F8,
        S_CLK_GO, S_CLK_WAIT, S_CLK_F8, S_STOP_FC, S_STOP_F2, S_FLUSH
    } t_state;

    typedef enum logic [1:0] {
        SP_IDLE, SP_MUL, SP_DIV, SP_DONE
    } t_samp_st;

endpackage

// ===== hdl/mctg_samp.sv =====
// shared shift-add multiply and restoring divide unit
// samples = floor(dist * 5 * rate / (2 * bpm)); depends on mctg_pkg
module mctg_samp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [mctg_pkg::DIST_W-1:0] i_dist,
    input  logic [17:0]                 i_rate,
    input  logic [25:0]                 i_bpm,
    output logic                        o_done,
    output logic [mctg_pkg::NUM_W-1:0]  o_quot
);
    mctg_pkg::t_samp_st r_st, n_st;
    logic [mctg_pkg::CNT_W-1:0] r_cnt;
    logic [mctg_pkg::NUM_W-1:0] r_a, r_q;
    logic [mctg_pkg::MUL_W-1:0] r_m;
    logic [mctg_pkg::DIV_W-1:0] r_rem, r_dv;
    logic [mctg_pkg::DIV_W:0]   c_t;
    logic                       c_ge;

    assign c_t  = {r_rem, r_q[mctg_pkg::NUM_W-1]};
    assign c_ge = c_t >= {1'b0, r_dv};

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mctg_pkg::SP_IDLE: if (i_start) n_st = mctg_pkg::SP_MUL;
            mctg_pkg::SP_MUL:
                if (r_cnt == mctg_pkg::CNT_W'(mctg_pkg::MUL_W - 1)) n_st = mctg_pkg::SP_DIV;
            mctg_pkg::SP_DIV:
                if (r_cnt == mctg_pkg::CNT_W'(mctg_pkg::NUM_W - 1)) n_st = mctg_pkg::SP_DONE;
            mctg_pkg::SP_DONE: n_st = mctg_pkg::SP_IDLE;
            default: n_st = mctg_pkg::SP_IDLE;
        endcase
    end

    always_comb begin
        o_done = (r_st == mctg_pkg::SP_DONE);
        o_quot = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= mctg_pkg::SP_IDLE;
            r_cnt <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                mctg_pkg::SP_IDLE: begin
                    r_cnt <= '0;
                    // quotient stays readable until the next start
                    if (i_start) begin
                        r_a  <= {{(mctg_pkg::NUM_W - mctg_pkg::DIST_W){1'b0}}, i_dist};
                        r_m  <= {3'b0, i_rate} + {1'b0, i_rate, 2'b0};
                        r_dv <= (i_bpm == 26'd0) ? 27'd2 : {i_bpm, 1'b0};
                        r_q  <= '0;
                    end
                end
                mctg_pkg::SP_MUL: begin
                    // r_q accumulates the product
                    if (r_m[0]) r_q <= r_q + r_a;
                    r_a <= {r_a[mctg_pkg::NUM_W-2:0], 1'b0};
                    r_m <= r_m >> 1;
                    r_rem <= '0;
                    if (r_cnt == mctg_pkg::CNT_W'(mctg_pkg::MUL_W - 1)) r_cnt <= '0;
                    else r_cnt <= r_cnt + 1'b1;
                end
                mctg_pkg::SP_DIV: begin
                    r_rem <= c_ge ? mctg_pkg::DIV_W'(c_t - {1'b0, r_dv})
                                  : c_t[mctg_pkg::DIV_W-1:0];
                    r_q   <= {r_q[mctg_pkg::NUM_W-2:0], c_ge};
                    r_cnt <= r_cnt + 1'b1;
                end
                mctg_pkg::SP_DONE: r_cnt <= '0;
                default: r_cnt <= '0;
            endcase
        end
    end
endmodule

// ===== hdl/mctg_outq.sv =====
// holding stage and output register; the held message gets its last flag at flush
// depends on mctg_pkg
module mctg_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  mctg_pkg::t_msg              i_msg,
    input  logic                        i_flush,
    output logic                        o_rdy,
    output logic                        o_held,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_status_byte,
    output logic [6:0]                  o_data_low,
    output logic [6:0]                  o_data_high,
    output logic [mctg_pkg::OFS_W-1:0]  o_sample_offset,
    output logic                        o_last_of_block
);
    mctg_pkg::t_msg r_h, r_o;
    logic r_hv, r_ov, r_last;

    assign o_rdy           = !r_hv || !r_ov;
    assign o_held          = r_hv;
    assign o_out_valid     = r_ov;
    assign o_status_byte   = r_o.status;
    assign o_data_low      = r_o.dlo;
    assign o_data_high     = r_o.dhi;
    assign o_sample_offset = r_o.offset;
    assign o_last_of_block = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            if (i_push && o_rdy) begin
                if (r_hv) begin
                    r_o    <= r_h;
                    r_last <= 1'b0;
                    r_ov   <= 1'b1;
                end
                r_h  <= i_msg;
                r_hv <= 1'b1;
            end else if (i_flush && o_rdy && r_hv) begin
                r_o    <= r_h;
                r_last <= 1'b1;
                r_ov   <= 1'b1;
                r_hv   <= 1'b0;
            end
        end
    end
endmodule

// ===== hdl/midi_clock_transport_generator.sv =====
// top level: transport report sequencer driving a shared sample offset unit
// depends on mctg_pkg, mctg_samp, mctg_outq
//
// Usage: one transport report per audio block is taken on the input channel
// (i_in_valid / o_in_ready). It produces zero to 32 MIDI real-time and song
// position messages on the output channel (o_out_valid / i_out_ready) in
// time order; the last one carries o_last_of_block. Registers are written on
// the cfg channel (index 0 clock enable, index 1 sample rate), which is
// always ready. Each sample offset costs one pass of the shared
// multiply/divide unit: a shift-add multiply, then a restoring divide, then
// a handoff. The input is not ready while a report is in work. The last
// message of a report is held until the report finishes, then moves to the
// output register; the next report may be taken while it waits there. A
// stalled receiver stalls the sequencer once both the output register and
// the holding stage are full. Synchronous reset empties the channels and
// restores clock enable 1, 44100 Hz and 120 bpm history.
module midi_clock_transport_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_position_valid,
    input  logic signed [47:0]         i_ppq_position,
    input  logic [25:0]                i_tempo_bpm,
    input  logic                       i_is_playing,
    input  logic [12:0]                i_block_length,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_status_byte,
    output logic [6:0]                 o_data_low,
    output logic [6:0]                 o_data_high,
    output logic [11:0]                o_sample_offset,
    output logic                       o_last_of_block,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [17:0]                i_cfg_data
);
    mctg_pkg::t_state r_st, n_st;

    logic        r_en;
    logic [17:0] r_rate;
    logic        r_was_playing, r_running, r_pending, r_last_play;
    logic [47:0] r_start_pos, r_last_pos, r_raw;
    logic [25:0] r_last_tempo, r_tempo;
    logic        r_valid, r_play, r_moved;
    logic [mctg_pkg::BLK_W-1:0]  r_blk;
    logic [mctg_pkg::DIST_W-1:0] r_after;
    logic [mctg_pkg::KK_W-1:0]   r_kk;
    logic [mctg_pkg::CNT_W-1:0]  r_i, r_cnt;

    logic                         c_changed;
    logic [48:0]                  c_bsum, c_diff;
    logic [34:0]                  c_beats;
    logic                         c_dpos;
    logic [52:0]                  c_d24;
    logic [mctg_pkg::DIST_W-1:0]  c_sdist, c_cdist, c_ad, c_dist;
    logic [15:0]                  c_frac, c_d0;
    logic                         c_slt, c_cap, c_go;

    logic                         samp_start, samp_done;
    logic [mctg_pkg::NUM_W-1:0]   samp_q;
    logic                         q_push, q_flush, q_rdy, q_held;
    mctg_pkg::t_msg               q_msg;

    assign o_in_ready  = (r_st == mctg_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign c_changed = (r_raw != r_last_pos) || (r_tempo != r_last_tempo)
                    || (r_play != r_last_play);
    // ceiling of 16ths, computed on the offset-binary position
    assign c_bsum  = {1'b0, r_raw ^ 48'h8000_0000_0000} + 49'd16383;
    assign c_beats = c_bsum[48:14] - 35'h2_0000_0000;
    assign c_diff  = {r_start_pos[47], r_start_pos} - {r_raw[47], r_raw};
    assign c_dpos  = !c_diff[48] && (c_diff != 49'd0);
    assign c_d24   = {1'b0, c_diff[47:0], 4'b0} + {2'b0, c_diff[47:0], 3'b0};
    assign c_sdist = !c_dpos ? '0 :
                     (c_d24 > 53'h1_0000_0000) ? 33'h1_0000_0000 : c_d24[32:0];
    assign c_frac  = {r_raw[11:0], 4'b0} + {r_raw[12:0], 3'b0};
    assign c_d0    = 16'd0 - c_frac;
    assign c_ad    = r_after - {17'b0, c_d0};
    assign c_cdist = {r_kk, 16'b0} + {17'b0, c_d0};
    assign c_dist  = (r_st == mctg_pkg::S_START_GO) ? c_sdist : c_cdist;
    assign c_slt   = (samp_q[mctg_pkg::NUM_W-1:mctg_pkg::BLK_W] == '0)
                  && (samp_q[mctg_pkg::BLK_W-1:0] < r_blk);
    assign c_cap   = (r_cnt >= mctg_pkg::CNT_W'(mctg_pkg::MAX_MSG));
    assign c_go    = c_cap || q_rdy;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            mctg_pkg::S_IDLE: if (i_in_valid) n_st = mctg_pkg::S_EVAL;
            mctg_pkg::S_EVAL: begin
                if (!r_valid || !(c_changed && r_en)) n_st = mctg_pkg::S_IDLE;
                else if (r_play) begin
                    if (!r_was_playing)
                        n_st = (c_beats != 35'd0) ? mctg_pkg::S_POS_F2 : mctg_pkg::S_START_GO;
                    else if (r_pending) n_st = mctg_pkg::S_START_GO;
                    else if (r_running) n_st = mctg_pkg::S_CLK_GO;
                    else n_st = mctg_pkg::S_FLUSH;
                end else if (r_was_playing) n_st = mctg_pkg::S_STOP_FC;
                else if (r_raw != r_last_pos) n_st = mctg_pkg::S_STOP_F2;
                else n_st = mctg_pkg::S_FLUSH;
            end
            mctg_pkg::S_POS_F2: if (c_go) n_st = mctg_pkg::S_START_GO;
            mctg_pkg::S_START_GO: n_st = mctg_pkg::S_START_WAIT;
            mctg_pkg::S_START_WAIT:
                if (samp_done) n_st = c_slt ? mctg_pkg::S_START_FA : mctg_pkg::S_FLUSH;
            mctg_pkg::S_START_FA: if (c_go) n_st = mctg_pkg::S_START_F8;
            mctg_pkg::S_START_F8: if (c_go) n_st = mctg_pkg::S_CLK_GO;
            mctg_pkg::S_CLK_GO:
                n_st = (r_i == mctg_pkg::CNT_W'(mctg_pkg::MAX_MSG) || c_cap)
                       ? mctg_pkg::S_FLUSH : mctg_pkg::S_CLK_WAIT;
            mctg_pkg::S_CLK_WAIT:
                if (samp_done) n_st = c_slt ? mctg_pkg::S_CLK_F8 : mctg_pkg::S_FLUSH;
            mctg_pkg::S_CLK_F8: if (c_go) n_st = mctg_pkg::S_CLK_GO;
            mctg_pkg::S_STOP_FC:
                if (c_go) n_st = r_moved ? mctg_pkg::S_STOP_F2 : mctg_pkg::S_FLUSH;
            mctg_pkg::S_STOP_F2: if (c_go) n_st = mctg_pkg::S_FLUSH;
            mctg_pkg::S_FLUSH: if (q_rdy || !q_held) n_st = mctg_pkg::S_IDLE;
            default: n_st = mctg_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        samp_start = (r_st == mctg_pkg::S_START_GO) ||
                     (r_st == mctg_pkg::S_CLK_GO && n_st == mctg_pkg::S_CLK_WAIT);
        q_flush    = (r_st == mctg_pkg::S_FLUSH);
        q_push     = 1'b0;
        q_msg      = '{status: mctg_pkg::ST_CLOCK, dlo: 7'd0, dhi: 7'd0,
                       offset: samp_q[mctg_pkg::OFS_W-1:0]};
        unique case (r_st)
            mctg_pkg::S_POS_F2, mctg_pkg::S_STOP_F2: begin
                q_push = !c_cap;
                q_msg  = '{status: mctg_pkg::ST_POS, dlo: c_beats[6:0],
                           dhi: c_beats[13:7], offset: '0};
            end
            mctg_pkg::S_START_FA: begin
                q_push       = !c_cap;
                q_msg.status = (r_start_pos == 48'd0) ? mctg_pkg::ST_START
                                                      : mctg_pkg::ST_CONT;
            end
            mctg_pkg::S_START_F8, mctg_pkg::S_CLK_F8: q_push = !c_cap;
            mctg_pkg::S_STOP_FC: begin
                q_push = !c_cap;
                q_msg  = '{status: mctg_pkg::ST_STOP, dlo: 7'd0, dhi: 7'd0, offset: '0};
            end
            default: q_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st          <= mctg_pkg::S_IDLE;
            r_en          <= 1'b1;
            r_rate        <= mctg_pkg::RATE_RST;
            r_was_playing <= 1'b0;
            r_running     <= 1'b0;
            r_pending     <= 1'b0;
            r_start_pos   <= '0;
            r_last_pos    <= '0;
            r_last_tempo  <= mctg_pkg::TEMPO_RST;
            r_last_play   <= 1'b0;
            r_cnt         <= '0;
        end else begin
            r_st <= n_st;
            if (i_cfg_valid) begin
                if (i_cfg_index == mctg_pkg::CFG_ENABLE) r_en <= i_cfg_data[0];
                else if (i_cfg_index == mctg_pkg::CFG_RATE) r_rate <= i_cfg_data;
            end
            if (q_push && q_rdy) r_cnt <= r_cnt + 1'b1;
            unique case (r_st)
                mctg_pkg::S_IDLE: begin
                    r_cnt <= '0;
                    if (i_in_valid) begin
                        r_valid <= i_position_valid;
                        r_raw   <= i_ppq_position;
                        r_tempo <= i_tempo_bpm;
                        r_play  <= i_is_playing;
                        r_blk   <= (i_block_length > 13'(mctg_pkg::MAX_BLOCK))
                                   ? 13'(mctg_pkg::MAX_BLOCK) : i_block_length;
                    end
                end
                mctg_pkg::S_EVAL: begin
                    r_moved <= (r_raw != r_last_pos);
                    r_kk    <= '0;
                    r_i     <= '0;
                    if (!r_valid) begin
                        r_last_pos   <= '0;
                        r_last_tempo <= mctg_pkg::TEMPO_RST;
                        r_last_play  <= 1'b0;
                    end else begin
                        if (c_changed && r_en && r_play && !r_was_playing) begin
                            r_start_pos <= {c_beats[33:0], 14'b0};
                            r_pending   <= 1'b1;
                            r_running   <= 1'b0;
                        end
                        r_was_playing <= r_play;
                        r_last_pos    <= r_raw;
                        r_last_tempo  <= r_tempo;
                        r_last_play   <= r_play;
                    end
                end
                mctg_pkg::S_START_GO: r_after <= c_sdist;
                mctg_pkg::S_START_F8: if (c_go) begin
                    r_pending <= 1'b0;
                    r_running <= 1'b1;
                    // first clock strictly after the start point
                    r_kk <= (r_after >= {17'b0, c_d0}) ? c_ad[32:16] + 1'b1 : '0;
                end
                mctg_pkg::S_CLK_F8: if (c_go) begin
                    r_kk <= r_kk + 1'b1;
                    r_i  <= r_i + 1'b1;
                end
                mctg_pkg::S_STOP_FC: if (c_go) begin
                    r_running <= 1'b0;
                    r_pending <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    mctg_samp u_samp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (samp_start),
        .i_dist  (c_dist),
        .i_rate  (r_rate),
        .i_bpm   (r_tempo),
        .o_done  (samp_done),
        .o_quot  (samp_q)
    );

    mctg_outq u_outq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (q_push),
        .i_msg           (q_msg),
        .i_flush         (q_flush),
        .o_rdy           (q_rdy),
        .o_held          (q_held),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status_byte   (o_status_byte),
        .o_data_low      (o_data_low),
        .o_data_high     (o_data_high),
        .o_sample_offset (o_sample_offset),
        .o_last_of_block (o_last_of_block)
    );

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !q_held)
        else $error("held message left over at idle");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mctg_pkg::CNT_W'(mctg_pkg::MAX_MSG))
        else $error("message count beyond cap");

    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        samp_done |-> (r_st == mctg_pkg::S_START_WAIT || r_st == mctg_pkg::S_CLK_WAIT))
        else $error("offset result outside a wait state");

    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_st == mctg_pkg::S_EVAL))
        else $error("accepted report not evaluated");
endmodule

// ===== dv/midi_clock_transport_generator_tb.sv =====
// self-checking testbench for midi_clock_transport_generator: a burst driver, a
// stalling receiver and a monitor that checks each message against a transport predictor
// depends on mctg_pkg and the midi_clock_transport_generator rtl
`timescale 1ns / 1ps

module midi_clock_transport_generator_tb;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          DRAIN_CYCLES   = 3000;
    localparam int          LONG_STALL     = 2000;
    localparam int          RUN_ITEMS      = 70;
    localparam logic [47:0] SIGN_BIT       = 48'h800000000000;
    localparam longint unsigned DIST_CAP   = 64'h100000000;

    typedef struct {
        bit          pv;
        logic [47:0] pos;
        logic [25:0] tempo;
        bit          play;
        logic [12:0] blk;
    } t_report;

    typedef struct {
        mctg_pkg::t_msg msg;
        bit   last;
    } t_exp_msg;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic i_position_valid = 1'b0;
    logic signed [47:0] i_ppq_position = '0;
    logic [25:0] i_tempo_bpm = '0;
    logic i_is_playing = 1'b0;
    logic [12:0] i_block_length = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [7:0] o_status_byte;
    logic [6:0] o_data_low;
    logic [6:0] o_data_high;
    logic [11:0] o_sample_offset;
    logic o_last_of_block;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [1:0] i_cfg_index = '0;
    logic [17:0] i_cfg_data = '0;

    midi_clock_transport_generator DUT (.*);

    always #5 i_clk = ~i_clk;

    t_report  report_q[$];
    t_exp_msg msg_exp_q[$];
    t_exp_msg block_msgs[$];
    int       errors = 0;
    int       reports_taken = 0;

    // predictor copy of the block's registers and transport history
    bit          pr_enable;
    int unsigned pr_rate;
    bit          pr_was_playing, pr_running, pr_pending, pr_last_playing;
    longint      pr_start_pos, pr_last_pos;
    logic [25:0] pr_last_tempo;

    function automatic longint unsigned offset_of(longint unsigned span, longint unsigned bpm);
        return (span * 5 * longint'(pr_rate)) / (2 * bpm);
    endfunction

    function automatic longint unsigned sixteenth_count(logic [47:0] raw);
        longint unsigned biased;
        biased = {16'h0, raw ^ SIGN_BIT};
        return ((biased + 16383) >> 14) - (64'd1 << 33);
    endfunction

    function automatic void add_msg(logic [7:0] st, longint unsigned cnt, longint unsigned ofs);
        t_exp_msg e;
        if (block_msgs.size() >= mctg_pkg::MAX_MSG)
            return;
        e.msg.status = st;
        e.msg.dlo    = (st == mctg_pkg::ST_POS) ? cnt[6:0] : 7'd0;
        e.msg.dhi    = (st == mctg_pkg::ST_POS) ? cnt[13:7] : 7'd0;
        e.msg.offset = ofs[mctg_pkg::OFS_W-1:0];
        e.last       = 1'b0;
        block_msgs.push_back(e);
    endfunction

    function automatic void predict_transport(t_report r);
        longint          pos;
        longint unsigned blk, bpm, frac, d0, beats, after, k0, span, s;
        longint          diff;
        bit              has_after;
        pos = $signed(r.pos);
        blk = (r.blk > mctg_pkg::MAX_BLOCK) ? mctg_pkg::MAX_BLOCK : r.blk;
        block_msgs.delete();
        if (!r.pv) begin
            pr_last_pos = 0;
            pr_last_tempo = mctg_pkg::TEMPO_RST;
            pr_last_playing = 1'b0;
            return;
        end
        if ((pos != pr_last_pos || r.tempo != pr_last_tempo || r.play != pr_last_playing)
                && pr_enable) begin
            bpm = (r.tempo == 0) ? 1 : r.tempo;
            if (r.play) begin
                frac = ({16'h0, r.pos} * 24) & 64'hFFFF;
                d0 = (65536 - frac) & 64'hFFFF;
                has_after = 1'b0;
                after = 0;
                if (!pr_was_playing) begin
                    beats = sixteenth_count(r.pos);
                    if (beats != 0)
                        add_msg(mctg_pkg::ST_POS, beats, 0);
                    pr_start_pos = beats & 64'h3FFFFFFFF;
                    if (beats[33])
                        pr_start_pos -= (64'd1 << 34);
                    pr_start_pos *= 16384;
                    pr_pending = 1'b1;
                    pr_running = 1'b0;
                end
                if (pr_pending) begin
                    diff = pr_start_pos - pos;
                    span = 0;
                    if (diff > 0) begin
                        span = diff * 24;
                        if (span > DIST_CAP)
                            span = DIST_CAP;
                    end
                    s = offset_of(span, bpm);
                    if (s < blk) begin
                        add_msg(pr_start_pos == 0 ? mctg_pkg::ST_START : mctg_pkg::ST_CONT,
                                0, s);
                        add_msg(mctg_pkg::ST_CLOCK, 0, s);
                        pr_pending = 1'b0;
                        pr_running = 1'b1;
                        has_after = 1'b1;
                        after = span;
                    end
                end
                if (pr_running && !pr_pending) begin
                    k0 = 0;
                    if (has_after && after >= d0)
                        k0 = (after - d0) / 65536 + 1;
                    for (int i = 0; i < mctg_pkg::MAX_MSG; i++) begin
                        s = offset_of(d0 + (k0 + i) * 65536, bpm);
                        if (s >= blk || block_msgs.size() >= mctg_pkg::MAX_MSG)
                            break;
                        add_msg(mctg_pkg::ST_CLOCK, 0, s);
                    end
                end
            end else begin
                if (pr_was_playing) begin
                    add_msg(mctg_pkg::ST_STOP, 0, 0);
                    pr_running = 1'b0;
                    pr_pending = 1'b0;
                end
                if (pos != pr_last_pos)
                    add_msg(mctg_pkg::ST_POS, sixteenth_count(r.pos), 0);
            end
        end
        pr_was_playing = r.play;
        pr_last_pos = pos;
        pr_last_tempo = r.tempo;
        pr_last_playing = r.play;
        if (block_msgs.size() > 0)
            block_msgs[block_msgs.size()-1].last = 1'b1;
        foreach (block_msgs[i])
            msg_exp_q.push_back(block_msgs[i]);
    endfunction

    // driver: bursts of reports separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_report r, nx;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r.pv = i_position_valid;
                r.pos = i_ppq_position;
                r.tempo = i_tempo_bpm;
                r.play = i_is_playing;
                r.blk = i_block_length;
                predict_transport(r);
                reports_taken++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (report_q.size() > 0) begin
                    nx = report_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_position_valid <= nx.pv;
                    i_ppq_position <= nx.pos;
                    i_tempo_bpm <= nx.tempo;
                    i_is_playing <= nx.play;
                    i_block_length <= nx.blk;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 10);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes mode now and then, plus one long hold-off
    int  rx_mode = 0;
    int  rx_mode_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (!long_hold_done && reports_taken >= 120) begin
                long_hold_done = 1;
                hold_left = LONG_STALL;
            end
            if (rx_mode_left == 0) begin
                rx_mode = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(50, 400);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= 1'($urandom_range(0, 1));
                    default: i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // monitor: compare every output transfer with the oldest expected message
    always @(posedge i_clk) begin
        t_exp_msg e;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (msg_exp_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected message status %h offset %0d", $time,
                         o_status_byte, o_sample_offset);
            end else begin
                e = msg_exp_q.pop_front();
                if (o_status_byte !== e.msg.status) begin
                    errors++;
                    $display("%0t: status expected %h actual %h", $time, e.msg.status,
                             o_status_byte);
                end
                if (o_data_low !== e.msg.dlo) begin
                    errors++;
                    $display("%0t: data_low expected %h actual %h", $time, e.msg.dlo,
                             o_data_low);
                end
                if (o_data_high !== e.msg.dhi) begin
                    errors++;
                    $display("%0t: data_high expected %h actual %h", $time, e.msg.dhi,
                             o_data_high);
                end
                if (o_sample_offset !== e.msg.offset) begin
                    errors++;
                    $display("%0t: offset expected %0d actual %0d", $time, e.msg.offset,
                             o_sample_offset);
                end
                if (o_last_of_block !== e.last) begin
                    errors++;
                    $display("%0t: last_of_block expected %b actual %b", $time, e.last,
                             o_last_of_block);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic add_report(bit pv, logic [47:0] pos, logic [25:0] tempo, bit play,
                              logic [12:0] blk);
        t_report r;
        r.pv = pv;
        r.pos = pos;
        r.tempo = tempo;
        r.play = play;
        r.blk = blk;
        report_q.push_back(r);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (report_q.size() > 0 || i_in_valid || msg_exp_q.size() > 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        if (idx == mctg_pkg::CFG_ENABLE)
            pr_enable = val[0];
        else
            pr_rate = val;
        i_cfg_valid <= 1'b0;
    endtask

    // musical runs: start somewhere, play a few blocks with advancing position, stop
    task automatic random_reports(int count);
        longint      pos, adv;
        logic [25:0] tempo;
        int          blk, nblk, made;
        int unsigned rate;
        made = 0;
        while (made < count) begin
            if ($urandom_range(0, 9) < 7) begin
                rate = (pr_rate == 0) ? 44100 : pr_rate;
                tempo = 26'($urandom_range(40, 300) * 65536 + $urandom_range(0, 65535));
                if ($urandom_range(0, 1))
                    pos = longint'($urandom_range(0, 2000)) * 4096;
                else
                    pos = longint'($urandom_range(0, 1 << 24)) - (1 << 22);
                nblk = $urandom_range(2, 8);
                for (int i = 0; i < nblk; i++) begin
                    blk = ($urandom_range(0, 15) == 0) ? 4096 : $urandom_range(32, 1024);
                    add_report(1'b1, 48'(pos), tempo, 1'b1, 13'(blk));
                    adv = longint'(blk) * tempo / (60 * longint'(rate));
                    if ($urandom_range(0, 15) == 0)
                        pos += $urandom_range(0, 200000);
                    else
                        pos += adv;
                end
                add_report(1'b1, 48'(pos), tempo, 1'b0, 13'd256);
                made += nblk + 1;
                if ($urandom_range(0, 2) == 0) begin
                    add_report(1'b1, 48'(pos + $urandom_range(1, 100000)), tempo, 1'b0,
                               13'd256);
                    made++;
                end
            end else begin
                add_report($urandom_range(0, 3) != 0, 48'({$urandom, $urandom}),
                           26'($urandom), 1'($urandom_range(0, 1)), 13'($urandom));
                made++;
            end
        end
    endtask

    initial begin
        pr_enable = 1'b1;
        pr_rate = mctg_pkg::RATE_RST;
        pr_was_playing = 0;
        pr_running = 0;
        pr_pending = 0;
        pr_start_pos = 0;
        pr_last_pos = 0;
        pr_last_tempo = mctg_pkg::TEMPO_RST;
        pr_last_playing = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_reg(mctg_pkg::CFG_ENABLE, 18'd1);
        write_reg(mctg_pkg::CFG_RATE, 18'd44100);

        add_report(1'b0, 48'h123456789ABC, 26'h3FFFFFF, 1'b1, 13'd100);  // invalid
        add_report(1'b1, 48'd0, mctg_pkg::TEMPO_RST, 1'b1, 13'd512);    // start at zero
        add_report(1'b1, 48'd3000, mctg_pkg::TEMPO_RST, 1'b1, 13'd512);
        add_report(1'b1, 48'd3000, mctg_pkg::TEMPO_RST, 1'b1, 13'd512); // unchanged
        add_report(1'b1, 48'd6000, mctg_pkg::TEMPO_RST, 1'b0, 13'd512); // stop, moved
        add_report(1'b1, 48'd6000, mctg_pkg::TEMPO_RST, 1'b0, 13'd512);
        add_report(1'b1, 48'd9000, mctg_pkg::TEMPO_RST, 1'b0, 13'd512); // position pointer
        add_report(1'b1, 48'h18000, mctg_pkg::TEMPO_RST, 1'b1, 13'd64); // continue on 16th
        add_report(1'b1, 48'h18000, mctg_pkg::TEMPO_RST, 1'b0, 13'd64);
        add_report(1'b1, 48'h18001, mctg_pkg::TEMPO_RST, 1'b1, 13'd1);  // pending start
        add_report(1'b1, 48'h18010, mctg_pkg::TEMPO_RST, 1'b1, 13'd1);
        add_report(1'b1, 48'h1C100, mctg_pkg::TEMPO_RST, 1'b1, 13'd256); // start passed
        add_report(1'b1, 48'h1C100, mctg_pkg::TEMPO_RST, 1'b0, 13'd256);
        add_report(1'b1, 48'h00001, mctg_pkg::TEMPO_RST, 1'b1, 13'd1);  // pending again
        add_report(1'b1, -48'sd1099511627776, mctg_pkg::TEMPO_RST, 1'b1, 13'd4096); // far
        add_report(1'b1, -48'sd40000, mctg_pkg::TEMPO_RST, 1'b0, 13'd100); // negative count
        add_report(1'b1, -48'sd40000, 26'd0, 1'b1, 13'd4096);           // tempo zero
        add_report(1'b1, 48'h7FFFFFFFFFFF, 26'd65535999, 1'b1, 13'd8191); // long block
        add_report(1'b1, 48'h7FFFFFFFFFFF, 26'd65535999, 1'b0, 13'd0);
        add_report(1'b1, 48'h800000000000, 26'd65536, 1'b1, 13'd0);     // empty block
        add_report(1'b1, 48'h800000000000, 26'd65535999, 1'b1, 13'd4096);
        add_report(1'b1, 48'h800000000000, 26'h3FFFFFF, 1'b0, 13'h1FFF);
        wait_idle();

        random_reports(RUN_ITEMS);
        wait_idle();
        write_reg(mctg_pkg::CFG_RATE, 18'd8000);
        random_reports(RUN_ITEMS);
        wait_idle();
        write_reg(mctg_pkg::CFG_RATE, 18'd192000);
        random_reports(RUN_ITEMS);
        wait_idle();
        write_reg(mctg_pkg::CFG_ENABLE, 18'd0);
        random_reports(RUN_ITEMS / 2);
        wait_idle();
        write_reg(mctg_pkg::CFG_ENABLE, 18'd1);
        write_reg(mctg_pkg::CFG_RATE, 18'd0);
        random_reports(RUN_ITEMS / 2);
        wait_idle();
        write_reg(mctg_pkg::CFG_RATE, 18'h3FFFF);
        random_reports(RUN_ITEMS);
        wait_idle();
        write_reg(mctg_pkg::CFG_RATE, 18'd48000);
        random_reports(RUN_ITEMS);
        wait_idle();

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
